FILE: design/icp_pkg.sv
// Package for the Mahonian number (inversion count) block.
// Holds field widths, the sequencer state type and the triangle-number helper.
// No dependencies.
package icp_pkg;

    localparam int LEN_W   = 5;   // permutation length field
    localparam int INV_W   = 8;   // inversion count field
    localparam int COUNT_W = 62;  // result field and table entries
    localparam int TOP_W   = 9;   // n(n-1)/2 for n up to 31

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_RUN  = 4'b0010,
        S_GAP  = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    // Largest inversion count of an n-element permutation.
    function automatic logic [TOP_W-1:0] max_inversions(input logic [LEN_W-1:0] n);
        logic [2*LEN_W-1:0] prod;
        prod = (2*LEN_W)'(n) * (2*LEN_W)'(n - LEN_W'(1));
        return prod[TOP_W:1];
    endfunction

endpackage

FILE: design/icp_ram.sv
// Generic RAM: one write port, two read ports, registered read data.
// No dependencies.
module icp_ram #(
    parameter int WIDTH = 62,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

FILE: design/inversion_count_permutations.sv
// Mahonian number block: counts the permutations of n elements with exactly
// k inversions. Depends on icp_pkg and icp_ram.
//
// A request carries a length n (values above MAX_LENGTH saturate to it) and an
// inversion count k; the block returns one count. The count is zero for n of
// zero, for k above n(n-1)/2 or for k of ROW_DEPTH or more, and one for n of
// one with k of zero; these answers skip the table. Otherwise the table is
// built row by row for lengths 2..n over columns 0..k, one cell per cycle
// through a single read / add-subtract / write pipeline over two row banks
// that swap roles each row, with a turnaround state after each row. Each cell is
// the entry above plus the entry to its left minus the entry one row up and i
// columns left; the row for length one is supplied as a constant, never stored.
// The input side is not ready while a request is worked on. A finished count
// sits in an output register; while it waits, the block takes the next request
// and holds that one's answer until the register frees up.
module inversion_count_permutations #(
    parameter int MAX_LENGTH = 20,
    parameter int ROW_DEPTH  = 256
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [icp_pkg::LEN_W-1:0]     i_perm_length,
    input  logic [icp_pkg::INV_W-1:0]     i_inversions,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [icp_pkg::COUNT_W-1:0]   o_count
);

    import icp_pkg::*;

    localparam int AW = $clog2(ROW_DEPTH);

    // Sequencer and request registers
    t_state             r_state, n_state;
    logic [LEN_W-1:0]   r_n, n_n;       // saturated length
    logic [INV_W-1:0]   r_k, n_k;       // target column
    logic [LEN_W-1:0]   r_i, n_i;       // row (permutation length) being built
    logic [AW-1:0]      r_j, n_j;       // column being issued
    logic               r_src, n_src;   // bank that holds the previous row
    logic               r_init, n_init; // previous row is the constant row for length one

    // Compute stage (lines up with registered RAM read data)
    logic               r_p_vld, n_p_vld;
    logic [AW-1:0]      r_p_j, n_p_j;
    logic               r_p_hasl, n_p_hasl; // column reaches back i places
    logic [COUNT_W-1:0] r_left, n_left;     // last computed cell, also the answer

    // Output register
    logic               r_ovld, n_ovld;
    logic [COUNT_W-1:0] r_count, n_count;

    // Datapath wires
    logic [LEN_W-1:0]   req_n;
    logic [TOP_W-1:0]   req_top;
    logic               req_zero;
    logic [AW-1:0]      rd_addr_a, rd_addr_b;
    logic [COUNT_W-1:0] b0_a, b0_b, b1_a, b1_b;
    logic [COUNT_W-1:0] up, up_back, left, cell_val;
    logic               we0, we1;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovld;
    assign o_count     = r_count;

    // Saturate the length and screen out the trivial answers
    always_comb begin
        req_n    = (i_perm_length > LEN_W'(MAX_LENGTH)) ? LEN_W'(MAX_LENGTH) : i_perm_length;
        req_top  = max_inversions(req_n);
        req_zero = (req_n == '0) || ({1'b0, i_inversions} > req_top)
                   || (32'(i_inversions) >= ROW_DEPTH);
    end

    // Issue: previous row at column j and at column j-i
    assign rd_addr_a = r_j;
    assign rd_addr_b = (r_j >= AW'(r_i)) ? (r_j - AW'(r_i)) : '0;

    // Compute: above + left - above-back; modular arithmetic, true counts fit
    always_comb begin
        if (r_init) begin
            up      = (r_p_j == '0) ? COUNT_W'(1) : '0;
            up_back = (r_p_j == AW'(r_i)) ? COUNT_W'(1) : '0;
        end else begin
            up      = r_src ? b1_a : b0_a;
            up_back = r_src ? b1_b : b0_b;
        end
        if (!r_p_hasl) begin
            up_back = '0;
        end
        left     = (r_p_j == '0) ? '0 : r_left;
        cell_val = up + left - up_back;
    end

    // Write into the bank that is not the source
    assign we0 = r_p_vld && r_src;
    assign we1 = r_p_vld && !r_src;

    icp_ram #(
        .WIDTH(COUNT_W),
        .DEPTH(ROW_DEPTH)
    ) u_bank0 (
        .i_clk    (i_clk),
        .i_we     (we0),
        .i_waddr  (r_p_j),
        .i_wdata  (cell_val),
        .i_raddr_a(rd_addr_a),
        .i_raddr_b(rd_addr_b),
        .o_rdata_a(b0_a),
        .o_rdata_b(b0_b)
    );

    icp_ram #(
        .WIDTH(COUNT_W),
        .DEPTH(ROW_DEPTH)
    ) u_bank1 (
        .i_clk    (i_clk),
        .i_we     (we1),
        .i_waddr  (r_p_j),
        .i_wdata  (cell_val),
        .i_raddr_a(rd_addr_a),
        .i_raddr_b(rd_addr_b),
        .o_rdata_a(b1_a),
        .o_rdata_b(b1_b)
    );

    // Sequencer
    always_comb begin
        n_state  = r_state;
        n_n      = r_n;
        n_k      = r_k;
        n_i      = r_i;
        n_j      = r_j;
        n_src    = r_src;
        n_init   = r_init;
        n_p_vld  = 1'b0;
        n_p_j    = r_p_j;
        n_p_hasl = r_p_hasl;
        n_left   = r_p_vld ? cell_val : r_left;
        n_ovld   = r_ovld && !i_out_ready;
        n_count  = r_count;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_n    = req_n;
                    n_k    = i_inversions;
                    n_i    = LEN_W'(2);
                    n_j    = '0;
                    n_src  = 1'b0;
                    n_init = 1'b1;
                    if (req_zero) begin
                        n_left  = '0;
                        n_state = S_DONE;
                    end else if (req_n == LEN_W'(1)) begin
                        n_left  = COUNT_W'(1);
                        n_state = S_DONE;
                    end else begin
                        n_state = S_RUN;
                    end
                end
            end
            S_RUN: begin
                // Issue one cell per cycle; stop the row at column k
                n_p_vld  = 1'b1;
                n_p_j    = r_j;
                n_p_hasl = (r_j >= AW'(r_i));
                if (r_j == AW'(r_k)) begin
                    n_state = S_GAP;
                end else begin
                    n_j = r_j + AW'(1);
                end
            end
            S_GAP: begin
                // Drain the last cell of the row, then swap banks
                n_j = '0;
                if (r_i == r_n) begin
                    n_state = S_DONE;
                end else begin
                    n_i     = r_i + LEN_W'(1);
                    n_src   = !r_src;
                    n_init  = 1'b0;
                    n_state = S_RUN;
                end
            end
            S_DONE: begin
                // Hold the answer until the output register is free
                if (!r_ovld || i_out_ready) begin
                    n_count = r_left;
                    n_ovld  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_p_vld <= 1'b0;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_p_vld <= n_p_vld;
            r_ovld  <= n_ovld;
        end
        r_n      <= n_n;
        r_k      <= n_k;
        r_i      <= n_i;
        r_j      <= n_j;
        r_src    <= n_src;
        r_init   <= n_init;
        r_p_j    <= n_p_j;
        r_p_hasl <= n_p_hasl;
        r_left   <= n_left;
        r_count  <= n_count;
    end

    // The compute stage only follows an issue cycle
    a_pipe_follows_issue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p_vld |-> $past(r_state == S_RUN))
        else $error("compute stage active without a preceding issue");

    // Row and column stay inside the requested table
    a_row_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> (r_i >= LEN_W'(2)) && (r_i <= r_n) && (r_j <= AW'(r_k)))
        else $error("table walk left the requested range");

    // A waiting answer is never overwritten
    a_hold_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) && r_ovld && !i_out_ready |=> (r_state == S_DONE))
        else $error("answer dropped while output register was full");

    // New requests are taken only when no row is in flight
    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_p_vld)
        else $error("row work still in flight while idle");

endmodule
